// ----- design/bdm_pkg.sv -----
// Shared types, constants and the color order table for the 2x2 demosaic.
// No dependencies; used by every module of the block but bdm_ram.
package bdm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WEFF_W     = COL_W + 1;
  localparam int FRAME_W    = 13;
  localparam int ORDER_W    = 5;
  localparam int NUM_ORDERS = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  localparam logic [FRAME_W-1:0] RESET_WIDTH  = FRAME_W'(640);
  localparam logic [FRAME_W-1:0] RESET_HEIGHT = FRAME_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_PATTERN_ORDER = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_RED     = 2'd0,
    KIND_GREEN_R = 2'd1,
    KIND_GREEN_B = 2'd2,
    KIND_BLUE    = 2'd3
  } kind_t;

  // Color kind per order and parity position {row odd, column odd}.
  localparam kind_t ORDER_TABLE [NUM_ORDERS][4] = '{
    '{KIND_RED,     KIND_GREEN_R, KIND_GREEN_B, KIND_BLUE},
    '{KIND_RED,     KIND_GREEN_R, KIND_BLUE,    KIND_GREEN_B},
    '{KIND_RED,     KIND_GREEN_B, KIND_GREEN_R, KIND_BLUE},
    '{KIND_RED,     KIND_GREEN_B, KIND_BLUE,    KIND_GREEN_R},
    '{KIND_RED,     KIND_BLUE,    KIND_GREEN_R, KIND_GREEN_B},
    '{KIND_RED,     KIND_BLUE,    KIND_GREEN_B, KIND_GREEN_R},
    '{KIND_GREEN_R, KIND_RED,     KIND_GREEN_B, KIND_BLUE},
    '{KIND_GREEN_R, KIND_RED,     KIND_BLUE,    KIND_GREEN_B},
    '{KIND_GREEN_R, KIND_GREEN_B, KIND_RED,     KIND_BLUE},
    '{KIND_GREEN_R, KIND_GREEN_B, KIND_BLUE,    KIND_RED},
    '{KIND_GREEN_R, KIND_BLUE,    KIND_RED,     KIND_GREEN_B},
    '{KIND_GREEN_R, KIND_BLUE,    KIND_GREEN_B, KIND_RED},
    '{KIND_GREEN_B, KIND_RED,     KIND_GREEN_R, KIND_BLUE},
    '{KIND_GREEN_B, KIND_RED,     KIND_BLUE,    KIND_GREEN_R},
    '{KIND_GREEN_B, KIND_GREEN_R, KIND_RED,     KIND_BLUE},
    '{KIND_GREEN_B, KIND_GREEN_R, KIND_BLUE,    KIND_RED},
    '{KIND_GREEN_B, KIND_BLUE,    KIND_RED,     KIND_GREEN_R},
    '{KIND_GREEN_B, KIND_BLUE,    KIND_GREEN_R, KIND_RED},
    '{KIND_BLUE,    KIND_RED,     KIND_GREEN_R, KIND_GREEN_B},
    '{KIND_BLUE,    KIND_RED,     KIND_GREEN_B, KIND_GREEN_R},
    '{KIND_BLUE,    KIND_GREEN_R, KIND_RED,     KIND_GREEN_B},
    '{KIND_BLUE,    KIND_GREEN_R, KIND_GREEN_B, KIND_RED},
    '{KIND_BLUE,    KIND_GREEN_B, KIND_RED,     KIND_GREEN_R},
    '{KIND_BLUE,    KIND_GREEN_B, KIND_GREEN_R, KIND_RED}
  };

  typedef struct packed {
    logic       command;
    logic [7:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;
  } out_item_t;

  // Frame geometry after clamping, as the front part uses it.
  typedef struct packed {
    logic [WEFF_W-1:0]  width;
    logic [FRAME_W-1:0] height;
  } geom_t;

  // Per-item classification: which pixels it emits and their position.
  typedef struct packed {
    logic a_valid;        // pixel (y-1, x-1)
    logic b_valid;        // pixel (y-1, x) at the last column
    logic oy_odd;
    logic x_odd;
    logic lower_present;  // y < height
  } pix_flags_t;

  typedef struct packed {
    pix_flags_t flags;
    logic [7:0] upper_left;
    logic [7:0] above;
    logic [7:0] lower_left;
    logic [7:0] cur;
  } job_t;

endpackage

// ----- design/bdm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Read-first on same-address access. No dependencies.
module bdm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bdm_front.sv -----
// Front part: position counters, line store and window capture.
// Depends on bdm_pkg and bdm_ram; feeds jobs to bdm_job_queue.
module bdm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  bdm_pkg::in_item_t           item,
  input  bdm_pkg::geom_t              geom,
  input  logic [bdm_pkg::QCNT_W-1:0]  q_level,
  output logic                        job_push,
  output bdm_pkg::job_t               job
);
  import bdm_pkg::*;

  logic [COL_W-1:0]   column_count;
  logic [FRAME_W-1:0] row_count;
  logic [7:0]         upper_left_sample;
  logic [7:0]         lower_left_sample;

  logic               s1_valid;
  pix_flags_t         s1_flags;
  logic [7:0]         s1_cur;

  logic               accept;
  logic [COL_W-1:0]   x;
  logic [FRAME_W-1:0] y;
  logic [WEFF_W-1:0]  x_plus;
  logic               row_end;
  logic [7:0]         cur;
  logic [7:0]         above;
  pix_flags_t         flags;

  // Conservative: room for the item in flight plus this one.
  assign full   = (QCNT_W'(q_level) + QCNT_W'(s1_valid)) >= QCNT_W'(QDEPTH);
  assign accept = push && !full;

  always_comb begin
    x       = ({1'b0, column_count} >= geom.width) ? '0 : column_count;
    y       = (row_count > geom.height) ? '0 : row_count;
    x_plus  = {1'b0, x} + WEFF_W'(1);
    row_end = x_plus >= geom.width;
    cur     = item.command ? 8'd0 : item.sample;
    flags.a_valid       = (y != '0) && (x != '0);
    flags.b_valid       = (y != '0) && row_end;
    flags.oy_odd        = ~y[0];
    flags.x_odd         = x[0];
    flags.lower_present = y < geom.height;
  end

  bdm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (x),
    .wdata (cur),
    .raddr (x),
    .rdata (above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= (y >= geom.height) ? '0 : y + FRAME_W'(1);
      end else begin
        column_count <= x_plus[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_flags <= flags;
      s1_cur   <= cur;
    end
  end

  // Line store data arrives in the cycle after the accept, with s1; the left
  // samples advance in item order here.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left_sample <= '0;
      lower_left_sample <= '0;
    end else if (s1_valid) begin
      upper_left_sample <= above;
      lower_left_sample <= s1_cur;
    end
  end

  always_comb begin
    job_push       = s1_valid && (s1_flags.a_valid || s1_flags.b_valid);
    job.flags      = s1_flags;
    job.upper_left = upper_left_sample;
    job.above      = above;
    job.lower_left = lower_left_sample;
    job.cur        = s1_cur;
  end

endmodule

// ----- design/bdm_job_queue.sv -----
// Short job queue between the front and back parts.
// Depends on bdm_pkg.
module bdm_job_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  bdm_pkg::job_t               push_job,
  input  logic                        pop,
  output logic                        head_valid,
  output bdm_pkg::job_t               head,
  output logic [bdm_pkg::QCNT_W-1:0]  level
);
  import bdm_pkg::*;

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_pop;

  assign do_pop     = pop && (count != '0);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign level      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- design/bdm_back.sv -----
// Back part: turns queued windows into RGB pixels in the output register,
// one per cycle while it is empty or being popped. Depends on bdm_pkg.
module bdm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bdm_pkg::ORDER_W-1:0]  order,
  input  logic                         head_valid,
  input  bdm_pkg::job_t                head,
  output logic                         job_pop,
  output logic                         empty,
  input  logic                         pop,
  output bdm_pkg::out_item_t           result
);
  import bdm_pkg::*;

  logic      out_valid;
  logic      a_done;
  out_item_t out_reg;

  logic       sel_b;
  logic       load;
  logic [7:0] s00, s01, s10, s11;
  logic       p01, p10, p11;
  logic       ox_odd;
  kind_t      kind;
  out_item_t  pix;

  function automatic logic [7:0] mean2(logic [7:0] a, logic [7:0] b, logic both);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    // absent site is already zero, so a lone site passes through
    return both ? sum[8:1] : sum[7:0];
  endfunction

  always_comb begin
    sel_b  = !(head.flags.a_valid && !a_done);
    p01    = !sel_b;
    p10    = head.flags.lower_present;
    p11    = p01 && p10;
    s00    = sel_b ? head.above : head.upper_left;
    s01    = sel_b ? 8'd0 : head.above;
    s10    = p10 ? (sel_b ? head.cur : head.lower_left) : 8'd0;
    s11    = (p11 && !sel_b) ? head.cur : 8'd0;
    ox_odd = sel_b ? head.flags.x_odd : ~head.flags.x_odd;
    kind   = ORDER_TABLE[(order < ORDER_W'(NUM_ORDERS)) ? order : '0]
                        [{head.flags.oy_odd, ox_odd}];
    unique case (kind)
      KIND_RED: begin
        pix.red   = s00;
        pix.green = mean2(s01, s10, p01 && p10);
        pix.blue  = s11;
      end
      KIND_GREEN_R: begin
        pix.red   = s01;
        pix.green = mean2(s00, s11, p11);
        pix.blue  = s10;
      end
      KIND_GREEN_B: begin
        pix.red   = s10;
        pix.green = mean2(s00, s11, p11);
        pix.blue  = s01;
      end
      default: begin
        pix.red   = s11;
        pix.green = mean2(s01, s10, p01 && p10);
        pix.blue  = s00;
      end
    endcase
    pix.frame_last = sel_b && !head.flags.lower_present;
  end

  assign load    = head_valid && (!out_valid || pop);
  assign job_pop = load && (sel_b || !head.flags.b_valid);
  assign empty   = !out_valid;
  assign result  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      a_done    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        a_done <= !job_pop;
      end
    end
    if (load) begin
      out_reg <= pix;
    end
  end

endmodule

// ----- design/bayer_2x2_demosaic_unit.sv -----
// Bayer 2x2 demosaic: a sample passes the front s1 register, job queue and
// output register to its first pixel; the front accepts one sample per cycle
// unless full, a last-column sample produces two pixels drained one per cycle
// by the back part as result is popped. Synchronous reset clears counters,
// queue, left samples and restores width 640, height 480, order 0; the line
// store is not cleared. Depends on bdm_pkg and the bdm_* modules.
module bayer_2x2_demosaic_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  bdm_pkg::in_item_t              item,
  output logic                           empty,
  input  logic                           pop,
  output bdm_pkg::out_item_t             result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import bdm_pkg::*;

  logic [FRAME_W-1:0] frame_width;
  logic [FRAME_W-1:0] frame_height;
  logic [ORDER_W-1:0] pattern_order;

  geom_t             geom;
  logic              job_push;
  job_t              job;
  logic              job_pop;
  logic              head_valid;
  job_t              head;
  logic [QCNT_W-1:0] q_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RESET_WIDTH;
      frame_height  <= RESET_HEIGHT;
      pattern_order <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[FRAME_W-1:0];
        CFG_PATTERN_ORDER: pattern_order <= cfg_data[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one; width clamps to the line store depth
  always_comb begin
    if (frame_width == '0) begin
      geom.width = WEFF_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      geom.width = WEFF_W'(MAX_WIDTH);
    end else begin
      geom.width = WEFF_W'(frame_width);
    end
    geom.height = (frame_height == '0) ? FRAME_W'(1) : frame_height;
  end

  bdm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .geom     (geom),
    .q_level  (q_level),
    .job_push (job_push),
    .job      (job)
  );

  bdm_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (job),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (q_level)
  );

  bdm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .order      (pattern_order),
    .head_valid (head_valid),
    .head       (head),
    .job_pop    (job_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
